>>> hw/rtl/spaced_symbol_rearranger_macros.svh
// Assertion macros for the spaced symbol rearranger.
// Used by ssr_dpath, the RTL file that carries concurrent checks; no other dependencies.
`ifndef SPACED_SYMBOL_REARRANGER_MACROS_SVH
`define SPACED_SYMBOL_REARRANGER_MACROS_SVH
`ifndef SYNTHESIS
`define SSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssr check failed");
`define SSR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssr check failed");
`else
`define SSR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SSR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/ssr_pkg.sv
// Shared types and constants for the spaced symbol rearranger.
// No dependencies; imported by every module of the block except ssr_ram.
`default_nettype none
package ssr_pkg;

    localparam int ALPHABET_DEF = 26;
    localparam int MAX_LEN_DEF  = 65536;
    localparam int SYM_W        = 5;
    localparam int CMD_W        = 2;

    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SYM_W-1:0] symbol;
    } in_word_t;

    typedef struct packed {
        logic [SYM_W-1:0] picked;
        logic             fail;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT_WR,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK
    } state_t;

    typedef struct packed {
        logic cnt_rd;
        logic cnt_wr;
        logic scan_start;
        logic scan_step;
        logic pick;
        logic clear;
    } ctl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } dp_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/ssr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ssr_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 26,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/ssr_ctrl.sv
// Controller state machine: sequences count, clear and draw commands.
// Depends on ssr_pkg; drives the datapath through ctl_cmd_t.
`default_nettype none
module ssr_ctrl
    import ssr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    input  wire logic [CMD_W-1:0] command,
    output logic                  cmd_stall,
    input  wire dp_sts_t          sts,
    output ctl_cmd_t              ctl
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid & ~cmd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_COUNT: state_next = ST_CNT_WR;
                        CMD_DRAW:  state_next = ST_SCAN;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CNT_WR: state_next = ST_IDLE;
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_PICK;
            ST_PICK:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_COUNT: ctl.cnt_rd     = 1'b1;
                        CMD_DRAW:  ctl.scan_start = 1'b1;
                        CMD_CLEAR: ctl.clear      = 1'b1;
                        default:   ctl            = '0;
                    endcase
                end
            end
            ST_CNT_WR: ctl.cnt_wr    = 1'b1;
            ST_SCAN:   ctl.scan_step = 1'b1;
            ST_PICK:   ctl.pick      = ~sts.out_busy;
            default:   ctl           = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/ssr_dpath.sv
// Datapath: count store with valid bits, scan comparator, pick history
// and result register. Depends on ssr_pkg, ssr_ram and the macros header.
`default_nettype none
`include "spaced_symbol_rearranger_macros.svh"
module ssr_dpath
    import ssr_pkg::*;
#(
    parameter int ALPHABET = ALPHABET_DEF,
    parameter int MAX_LEN  = MAX_LEN_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [SYM_W-1:0] symbol,
    input  wire ctl_cmd_t         ctl,
    output dp_sts_t               sts,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output out_word_t             res_word
);

    localparam int AW    = $clog2(ALPHABET);
    localparam int IDX_W = $clog2(ALPHABET + 1);
    localparam int CW    = $clog2(MAX_LEN + 1);
    localparam int XW    = (IDX_W > SYM_W) ? IDX_W : SYM_W;
    localparam logic [IDX_W-1:0] NONE = IDX_W'(ALPHABET);

    logic [ALPHABET-1:0] valid_reg;
    logic                rd_valid_reg;
    logic [AW-1:0]       sym_addr_reg;
    logic                sym_ok_reg;
    logic [AW-1:0]       scan_idx_reg;
    logic [AW-1:0]       cmp_idx_reg;
    logic                rd_pend_reg;
    logic [IDX_W-1:0]    best_reg;
    logic [CW-1:0]       best_cnt_reg;
    logic [IDX_W-1:0]    last_reg;
    logic [IDX_W-1:0]    before_reg;
    logic                out_valid_reg;
    out_word_t           out_word_reg;

    logic [XW-1:0]       sym_ext;
    logic                sym_ok;
    logic [AW-1:0]       in_addr;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [CW-1:0]       rdata;
    logic [CW-1:0]       eff_cnt;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [CW-1:0]       wr_data;
    logic [IDX_W-1:0]    cmp_idx_ext;
    logic                eligible;
    logic                found;

    assign sym_ext     = XW'(symbol);
    assign sym_ok      = (sym_ext < XW'(ALPHABET));
    assign in_addr     = sym_ok ? AW'(sym_ext) : '0;
    assign rd_en       = ctl.cnt_rd | ctl.scan_step;
    assign rd_addr     = ctl.cnt_rd ? in_addr : scan_idx_reg;
    assign eff_cnt     = rd_valid_reg ? rdata : '0;
    assign cmp_idx_ext = IDX_W'(cmp_idx_reg);
    assign eligible    = (cmp_idx_ext != last_reg) && (cmp_idx_ext != before_reg);
    assign found       = (best_reg != NONE);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sym_addr_reg;
        wr_data = eff_cnt;
        if (ctl.cnt_wr)
        begin
            wr_en = sym_ok_reg;
            if (eff_cnt < CW'(MAX_LEN))
            begin
                wr_data = eff_cnt + CW'(1);
            end
        end
        else if (ctl.pick)
        begin
            wr_en   = found;
            wr_addr = AW'(best_reg);
            wr_data = best_cnt_reg - CW'(1);
        end
    end

    ssr_ram #(
        .WIDTH (CW),
        .DEPTH (ALPHABET)
    ) u_counts (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            last_reg      <= NONE;
            before_reg    <= NONE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= ctl.scan_step;
            if (ctl.clear)
            begin
                valid_reg  <= '0;
                last_reg   <= NONE;
                before_reg <= NONE;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.pick && found)
            begin
                before_reg <= last_reg;
                last_reg   <= best_reg;
            end
            if (ctl.pick)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (ctl.cnt_rd)
        begin
            sym_addr_reg <= in_addr;
            sym_ok_reg   <= sym_ok;
        end
        if (ctl.scan_start)
        begin
            scan_idx_reg <= '0;
            best_reg     <= NONE;
            best_cnt_reg <= '0;
        end
        else
        begin
            if (ctl.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + AW'(1);
                cmp_idx_reg  <= scan_idx_reg;
            end
            if (rd_pend_reg && eligible && (eff_cnt > best_cnt_reg))
            begin
                best_reg     <= cmp_idx_ext;
                best_cnt_reg <= eff_cnt;
            end
        end
        if (ctl.pick)
        begin
            out_word_reg.picked <= found ? SYM_W'(best_reg) : '0;
            out_word_reg.fail   <= ~found;
        end
    end

    assign sts.scan_last = (scan_idx_reg == AW'(ALPHABET - 1));
    assign sts.out_busy  = out_valid_reg & res_stall;
    assign res_valid     = out_valid_reg;
    assign res_word      = out_word_reg;

    `SSR_ASSERT_NXT(a_hist_shift, clk, rst_n, ctl.pick && found, last_reg == $past(best_reg))
    `SSR_ASSERT_IMP(a_pick_spaced, clk, rst_n, ctl.pick && found,
        (best_reg != last_reg) && (best_reg != before_reg))
    `SSR_ASSERT_IMP(a_best_nonzero, clk, rst_n, ctl.pick && found, best_cnt_reg != '0)

endmodule
`default_nettype wire

>>> hw/rtl/spaced_symbol_rearranger.sv
// Spaced symbol rearranger: a count reads, then writes back in a write state;
// clear and any other command do not stall. Draw: a scan with one count RAM read per
// cycle, a drain state, then a pick/update state; only after it is a new word taken.
// One command at a time; a waiting result stalls only a later draw, in its pick cycle.
// Reset (asynchronous, active low) empties all counts through per-entry valid bits
// and sets the pick history to none; no clearing pass is needed.
`default_nettype none
module spaced_symbol_rearranger
    import ssr_pkg::*;
#(
    parameter int ALPHABET = ALPHABET_DEF,
    parameter int MAX_LEN  = MAX_LEN_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire in_word_t  cmd_word,
    output logic           res_valid,
    input  wire logic      res_stall,
    output out_word_t      res_word
);

    ctl_cmd_t ctl;
    dp_sts_t  sts;

    ssr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .command   (cmd_word.command),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    ssr_dpath #(
        .ALPHABET (ALPHABET),
        .MAX_LEN  (MAX_LEN)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .symbol    (cmd_word.symbol),
        .ctl       (ctl),
        .sts       (sts),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule
`default_nettype wire

>>> bench/spaced_symbol_rearranger_checker.sv
// Checker for the spaced symbol rearranger: follows the command and result channels,
// keeps its own symbol histogram and pick history, and compares every result word.
// Depends on ssr_pkg for the word types and command codes.
module spaced_symbol_rearranger_checker
    import ssr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_stall,
    input  in_word_t  cmd_word,
    input  logic      res_valid,
    input  logic      res_stall,
    input  out_word_t res_word,
    output int        mismatches,
    output int        outstanding
);

    localparam logic [SYM_W-1:0] NO_PICK = SYM_W'(ALPHABET_DEF);

    logic [16:0]      tally [ALPHABET_DEF];
    logic [SYM_W-1:0] recent;
    logic [SYM_W-1:0] older;
    out_word_t        picks_due [$];

    always @(posedge clk)
    begin : track
        out_word_t   want;
        out_word_t   got;
        int          best;
        logic [16:0] best_n;
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET_DEF; i++)
                tally[i] = '0;
            recent = NO_PICK;
            older = NO_PICK;
            picks_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                got = res_word;
                if (picks_due.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual picked=%0d fail=%0b",
                             $time, got.picked, got.fail);
                    mismatches++;
                end
                else
                begin
                    want = picks_due.pop_front();
                    if (got.picked !== want.picked)
                    begin
                        $display("%0t: picked mismatch, expected %0d, actual %0d",
                                 $time, want.picked, got.picked);
                        mismatches++;
                    end
                    if (got.fail !== want.fail)
                    begin
                        $display("%0t: fail mismatch, expected %0b, actual %0b",
                                 $time, want.fail, got.fail);
                        mismatches++;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                case (cmd_word.command)
                    CMD_COUNT:
                    begin
                        if (cmd_word.symbol < ALPHABET_DEF
                            && tally[cmd_word.symbol] < MAX_LEN_DEF)
                            tally[cmd_word.symbol]++;
                    end
                    CMD_CLEAR:
                    begin
                        for (int i = 0; i < ALPHABET_DEF; i++)
                            tally[i] = '0;
                        recent = NO_PICK;
                        older = NO_PICK;
                    end
                    CMD_DRAW:
                    begin
                        best = ALPHABET_DEF;
                        best_n = '0;
                        for (int j = 0; j < ALPHABET_DEF; j++)
                        begin
                            if (j != recent && j != older && tally[j] > best_n)
                            begin
                                best_n = tally[j];
                                best = j;
                            end
                        end
                        if (best == ALPHABET_DEF)
                        begin
                            want.picked = '0;
                            want.fail = 1'b1;
                        end
                        else
                        begin
                            tally[best]--;
                            older = recent;
                            recent = SYM_W'(best);
                            want.picked = SYM_W'(best);
                            want.fail = 1'b0;
                        end
                        picks_due = {picks_due, want};
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        outstanding <= picks_due.size();
    end

endmodule

>>> bench/spaced_symbol_rearranger_tb.sv
// Top of the spaced symbol rearranger bench: clock, reset, command stimulus and verdict.
// Depends on ssr_pkg, the block itself and spaced_symbol_rearranger_checker.
module spaced_symbol_rearranger_tb;
    import ssr_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;
    localparam int               CYCLE_LIMIT = 2000000;
    localparam int               DRAIN       = 64;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    in_word_t  cmd_word = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    out_word_t res_word;
    int        mismatches;
    int        outstanding;

    int send_pct = 31;
    int stall_pct = 46;
    int taken = 0;

    spaced_symbol_rearranger uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    spaced_symbol_rearranger_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd_word    (cmd_word),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_word    (res_word),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        res_stall <= ($urandom_range(99) < stall_pct);

    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym);
        while ($urandom_range(99) < send_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word.command <= cmd;
        cmd_word.symbol <= sym;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        if (cmd != CMD_SPARE && !(cmd == CMD_COUNT && sym >= ALPHABET_DEF))
            taken++;
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_idle, input int n);
        int stop;
        int kinds;
        int reps;
        int loaded;
        logic [SYM_W-1:0] sym;
        send_pct = sender_idle;
        stall_pct = receiver_idle;
        stop = taken + n;
        while (taken < stop)
        begin
            loaded = 0;
            if ($urandom_range(9) == 0)
                issue(CMD_W'($urandom_range(3)), SYM_W'($urandom_range(31)));
            kinds = $urandom_range(1, 5);
            repeat (kinds)
            begin
                sym = SYM_W'($urandom_range(ALPHABET_DEF - 1));
                reps = $urandom_range(1, 4);
                repeat (reps)
                begin
                    issue(CMD_COUNT, sym);
                    loaded++;
                    if ($urandom_range(15) == 0)
                        issue(CMD_COUNT, SYM_W'($urandom_range(31, ALPHABET_DEF)));
                    if ($urandom_range(15) == 0)
                        issue(CMD_SPARE, SYM_W'($urandom_range(31)));
                end
            end
            repeat (loaded + $urandom_range(2))
            begin
                issue(CMD_DRAW, SYM_W'($urandom_range(31)));
                if ($urandom_range(11) == 0)
                    issue(CMD_COUNT, SYM_W'($urandom_range(ALPHABET_DEF - 1)));
            end
            if ($urandom_range(3) != 0)
                issue(CMD_CLEAR, SYM_W'($urandom_range(31)));
        end
    endtask

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** spaced_symbol_rearranger: FAILED **");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(CMD_DRAW, 5'd0);
        issue(CMD_COUNT, 5'd0);
        issue(CMD_COUNT, 5'd25);
        issue(CMD_COUNT, 5'd25);
        issue(CMD_COUNT, 5'd31);
        issue(CMD_COUNT, 5'd26);
        issue(CMD_SPARE, 5'd31);
        issue(CMD_DRAW, 5'd31);
        issue(CMD_DRAW, 5'd0);
        issue(CMD_DRAW, 5'd0);
        issue(CMD_COUNT, 5'd1);
        issue(CMD_DRAW, 5'd0);
        issue(CMD_DRAW, 5'd0);
        issue(CMD_DRAW, 5'd0);
        issue(CMD_CLEAR, 5'd31);
        issue(CMD_COUNT, 5'd7);
        issue(CMD_COUNT, 5'd4);
        issue(CMD_DRAW, 5'd0);
        issue(CMD_DRAW, 5'd0);
        issue(CMD_DRAW, 5'd0);
        issue(CMD_CLEAR, 5'd0);
        issue(CMD_DRAW, 5'd0);

        run_phase(31, 46, 333);
        run_phase(46, 31, 333);
        run_phase(0, 0, 333);
        cmd_valid <= 1'b0;

        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN) @(posedge clk);

        if (mismatches == 0)
            $display("** spaced_symbol_rearranger: PASSED **");
        else
            $display("** spaced_symbol_rearranger: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/ssr_pkg.sv
hw/rtl/ssr_ram.sv
hw/rtl/ssr_ctrl.sv
hw/rtl/ssr_dpath.sv
hw/rtl/spaced_symbol_rearranger.sv
bench/spaced_symbol_rearranger_checker.sv
bench/spaced_symbol_rearranger_tb.sv
